/* rtl/idcs_pkg.sv */
// Package for the virtio input device configuration space.
// Holds select codes, register indexes, payload constants and the string tables.
// No dependencies.
`default_nettype none

package idcs_pkg;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_X_MAX = 1'b0;
    localparam logic CFG_Y_MAX = 1'b1;

    localparam logic [15:0] AXIS_MAX_RESET = 16'd16384;

    // Select codes of the select word.
    localparam logic [7:0] SEL_NAME    = 8'h01;
    localparam logic [7:0] SEL_SERIAL  = 8'h02;
    localparam logic [7:0] SEL_IDS     = 8'h03;
    localparam logic [7:0] SEL_EVBITS  = 8'h11;
    localparam logic [7:0] SEL_ABSINFO = 8'h12;

    // Event-bit subselects and axis-info subselects.
    localparam logic [7:0] SUB_EV_KEY = 8'd1;
    localparam logic [7:0] SUB_EV_REL = 8'd2;
    localparam logic [7:0] SUB_EV_ABS = 8'd3;
    localparam logic [7:0] SUB_ABS_X  = 8'd0;
    localparam logic [7:0] SUB_ABS_Y  = 8'd1;

    // Payload window of the configuration space.
    localparam logic [7:0] PAYLOAD_LO  = 8'd8;
    localparam logic [7:0] PAYLOAD_LEN = 8'd36;
    localparam logic [7:0] PAYLOAD_HI  = PAYLOAD_LO + PAYLOAD_LEN;

    // Strings, without the terminating zero.
    localparam int NAME_LEN   = 12;
    localparam int SERIAL_LEN = 9;
    localparam int IDS_LEN    = 2;

    localparam logic [7:0] NAME_CHARS [NAME_LEN] =
        '{"V", "i", "r", "t", "i", "o", " ", "m", "o", "u", "s", "e"};
    localparam logic [7:0] SERIAL_CHARS [SERIAL_LEN] =
        '{"s", "e", "r", "i", "a", "l", " ", "3", "4"};
    localparam logic [7:0] IDS_CHARS [IDS_LEN] = '{"4", "2"};

    // Payload sizes; the strings count their terminating zero.
    localparam logic [7:0] SIZE_NAME    = 8'(NAME_LEN + 1);
    localparam logic [7:0] SIZE_SERIAL  = 8'(SERIAL_LEN + 1);
    localparam logic [7:0] SIZE_IDS     = 8'(IDS_LEN + 1);
    localparam logic [7:0] SIZE_ABSINFO = 8'(5 * 4);
    localparam logic [7:0] SIZE_EV_KEY  = 8'd36;
    localparam logic [7:0] SIZE_EV_REL  = 8'd2;
    localparam logic [7:0] SIZE_EV_ABS  = 8'd1;

    // Event bitmaps: buttons 272 to 274, wheel, absolute X and Y.
    localparam int          BTN_FIRST   = 272;
    localparam logic [5:0]  EV_KEY_POS  = 6'((BTN_FIRST / 32) * 4);
    localparam logic [31:0] EV_KEY_BITS = 32'(7) << (BTN_FIRST % 32);
    localparam logic [31:0] EV_REL_BITS = 32'h0000_0100;
    localparam logic [31:0] EV_ABS_BITS = 32'h0000_0003;
    localparam logic [5:0]  ABS_MAX_POS = 6'd4;

    typedef struct packed {
        logic [15:0] x_max;
        logic [15:0] y_max;
    } idcs_cfg_t;

    function automatic logic [7:0] name_byte(input logic [6:0] k);
        logic [7:0] b;
        b = 8'h00;
        if (k < 7'(NAME_LEN))
        begin
            b = NAME_CHARS[k[3:0]];
        end
        return b;
    endfunction

    function automatic logic [7:0] serial_byte(input logic [6:0] k);
        logic [7:0] b;
        b = 8'h00;
        if (k < 7'(SERIAL_LEN))
        begin
            b = SERIAL_CHARS[k[3:0]];
        end
        return b;
    endfunction

    function automatic logic [7:0] ids_byte(input logic [6:0] k);
        logic [7:0] b;
        b = 8'h00;
        if (k < 7'(IDS_LEN))
        begin
            b = IDS_CHARS[k[0]];
        end
        return b;
    endfunction

    function automatic logic [7:0] size_of_select(input logic [7:0] sel,
                                                  input logic [7:0] sub);
        logic [7:0] s;
        s = 8'd0;
        priority case (sel)
            SEL_NAME:    s = SIZE_NAME;
            SEL_SERIAL:  s = SIZE_SERIAL;
            SEL_IDS:     s = SIZE_IDS;
            SEL_ABSINFO: s = SIZE_ABSINFO;
            SEL_EVBITS:
            begin
                priority if (sub == SUB_EV_KEY) s = SIZE_EV_KEY;
                else if (sub == SUB_EV_REL)     s = SIZE_EV_REL;
                else if (sub == SUB_EV_ABS)     s = SIZE_EV_ABS;
                else                            s = 8'd0;
            end
            default:     s = 8'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/idcs_decode.sv */
// Read decode of the configuration space: select word, strings, bitmaps, axis info.
// Depends on idcs_pkg.
`default_nettype none

module idcs_decode (
    input  wire logic              opcode,
    input  wire logic [7:0]        offset,
    input  wire logic [31:0]       select_word,
    input  wire idcs_pkg::idcs_cfg_t cfg,
    output logic [31:0]            read_data
);
    import idcs_pkg::*;

    logic [7:0] sel;
    logic [7:0] sub;
    logic [7:0] pos_full;
    logic [5:0] pos;
    logic       in_window;

    assign sel       = select_word[7:0];
    assign sub       = select_word[15:8];
    assign pos_full  = offset - PAYLOAD_LO;
    assign pos       = pos_full[5:0];
    assign in_window = (offset >= PAYLOAD_LO) && (offset < PAYLOAD_HI);

    always_comb
    begin
        logic [31:0] payload;
        logic [6:0]  k;
        payload = 32'd0;
        // Strings are assembled one byte lane at a time.
        for (int i = 0; i < 4; i++)
        begin
            k = 7'(pos) + 7'(i);
            priority case (sel)
                SEL_NAME:   payload[8*i +: 8] = name_byte(k);
                SEL_SERIAL: payload[8*i +: 8] = serial_byte(k);
                SEL_IDS:    payload[8*i +: 8] = ids_byte(k);
                default:    payload[8*i +: 8] = 8'h00;
            endcase
        end
        if (sel == SEL_EVBITS)
        begin
            priority if (sub == SUB_EV_ABS && pos == 6'd0)        payload = EV_ABS_BITS;
            else if (sub == SUB_EV_REL && pos == 6'd0)            payload = EV_REL_BITS;
            else if (sub == SUB_EV_KEY && pos == EV_KEY_POS)      payload = EV_KEY_BITS;
            else                                                  payload = 32'd0;
        end
        else if (sel == SEL_ABSINFO)
        begin
            priority if (pos == ABS_MAX_POS && sub == SUB_ABS_X)  payload = {16'd0, cfg.x_max};
            else if (pos == ABS_MAX_POS && sub == SUB_ABS_Y)      payload = {16'd0, cfg.y_max};
            else                                                  payload = 32'd0;
        end

        priority if (opcode == OP_WRITE)
            read_data = 32'd0;
        else if (offset == 8'd0)
            read_data = {select_word[31:24], size_of_select(sel, sub), select_word[15:0]};
        else if (in_window)
            read_data = payload;
        else
            read_data = 32'd0;
    end

endmodule

`default_nettype wire

/* rtl/input_device_config_space.sv */
// Top level of the virtio input (mouse) device configuration space.
// Depends on idcs_pkg and idcs_decode.
//
// Usage:
// Each item on the input channel is one bus access: opcode (read or write),
// a byte offset and the write data. Every accepted item yields exactly one
// item on the output channel carrying read_data; writes return zero.
// A write at offset zero stores the select word, and all later reads decode
// against it. Offset zero reads back that word with the payload size in
// bits 23:16; offsets 8 to 43 return payload bytes; other offsets read zero.
//
// The decode is one short combinational pass from the input ports into the
// output register, so one item per cycle is sustained while the receiver
// takes results. When the receiver stalls, the waiting result holds in the
// output register and one more item is taken into a skid register; in_stall
// rises only when that skid register is full, so it is a registered signal.
// Reset clears the select word and both valid flags, and loads both axis
// maxima with 16384. The x_max and y_max registers are written through the
// cfg_we / cfg_index / cfg_data port; the user must write them only while no
// access is in flight, since the block itself does not enforce it.
`default_nettype none

module input_device_config_space (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Access channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [7:0]  offset,
    input  wire logic [31:0] write_data,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      read_data,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    import idcs_pkg::*;

    logic        accept;
    logic        out_take;
    logic [31:0] result;

    logic [31:0] select_word_reg;
    idcs_cfg_t   cfg_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        skid_valid_reg;
    logic [31:0] skid_data_reg;

    assign accept   = in_valid && !in_stall;
    assign out_take = !out_valid_reg || !out_stall;

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;

    // The decode sees the select word as it stands before this item's write,
    // which matches the order of a bus access: a write returns zero anyway.
    idcs_decode u_decode (
        .opcode      (opcode),
        .offset      (offset),
        .select_word (select_word_reg),
        .cfg         (cfg_reg),
        .read_data   (result)
    );

    // Select word and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_word_reg <= 32'd0;
            cfg_reg.x_max   <= AXIS_MAX_RESET;
            cfg_reg.y_max   <= AXIS_MAX_RESET;
        end
        else
        begin
            if (accept && opcode == OP_WRITE && offset == 8'd0)
            begin
                select_word_reg <= write_data;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_X_MAX: cfg_reg.x_max <= cfg_data;
                    CFG_Y_MAX: cfg_reg.y_max <= cfg_data;
                endcase
            end
        end
    end

    // Output register with a one-entry skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept)
            begin
                out_data_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    // The skid stage only fills behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // An item accepted with room at the output appears there next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_take) |=> out_valid_reg)
        else $error("accepted item did not reach the output register");

    // A write at offset zero replaces the select word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_WRITE && offset == 8'd0)
        |=> select_word_reg == $past(write_data))
        else $error("select word not updated by write at offset zero");

    // A skid result moves to the output as soon as the receiver takes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> !skid_valid_reg)
        else $error("skid register not drained");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for input_device_config_space, the virtio mouse config space.
// It predicts each bus access and checks every read_data against that prediction.
// Depends on idcs_pkg and the RTL of input_device_config_space.
module testbench;
    import idcs_pkg::*;

    // Clock period is 4; the run is cut off after this many cycles.
    localparam int CYCLE_LIMIT = 200000;
    // Extra cycles waited after the last result so that the block can drain.
    localparam int SETTLE_CYCLES = 4;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES = 60;

    // Device strings; the payload size counts the terminating zero.
    localparam string MOUSE_NAME   = "Virtio mouse";
    localparam string MOUSE_SERIAL = "serial 34";
    localparam string MOUSE_IDS    = "42";

    // Payload sizes and bitmaps of the event-bits and axis-info selects.
    localparam logic [7:0]  KEY_BITMAP_BYTES = 8'd36;
    localparam logic [7:0]  REL_BITMAP_BYTES = 8'd2;
    localparam logic [7:0]  ABS_BITMAP_BYTES = 8'd1;
    localparam logic [7:0]  AXIS_INFO_BYTES  = 8'(5 * 4);
    // Buttons 272 to 274 fall into the ninth 32-bit word of the key bitmap.
    localparam int          BUTTON_WORD_POS  = 32;
    localparam logic [31:0] BUTTON_BITS      = 32'h0007_0000;
    localparam logic [31:0] WHEEL_BITS       = 32'h0000_0100;
    localparam logic [31:0] ABS_AXES_BITS    = 32'h0000_0003;
    // The axis maximum is the second word of the axis info.
    localparam int          AXIS_MAX_WORD_POS = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = OP_READ;
    logic [7:0]  offset = 8'd0;
    logic [31:0] write_data = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_X_MAX;
    logic [15:0] cfg_data = 16'd0;

    // Predicted device state: the select word and the two axis maxima.
    logic [31:0] select_word;
    logic [15:0] x_limit;
    logic [15:0] y_limit;

    logic [31:0] expected_reads[$];
    logic [31:0] want_read;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // Idle rates in percent for the sender and the receiver.
    int          send_idle_pct = 28;
    int          recv_stall_pct = 69;
    logic        hold_start = 1'b0;
    int          hold_left = 0;

    input_device_config_space i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .offset     (offset),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs on either channel.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Four bytes of a string starting at pos; bytes past the end read as zero,
    // which also covers the terminating zero.
    function automatic logic [31:0] text_word(input string s, input int pos);
        logic [31:0] w;
        int k;
        w = 32'd0;
        for (int i = 0; i < 4; i++)
        begin
            k = pos + i;
            if (k < s.len())
            begin
                w[8*i +: 8] = s[k];
            end
        end
        return w;
    endfunction

    function automatic logic [7:0] payload_size(input logic [7:0] sel, input logic [7:0] sub);
        case (sel)
            SEL_NAME:    return 8'(MOUSE_NAME.len() + 1);
            SEL_SERIAL:  return 8'(MOUSE_SERIAL.len() + 1);
            SEL_IDS:     return 8'(MOUSE_IDS.len() + 1);
            SEL_ABSINFO: return AXIS_INFO_BYTES;
            SEL_EVBITS:
            begin
                if (sub == SUB_EV_KEY)
                begin
                    return KEY_BITMAP_BYTES;
                end
                if (sub == SUB_EV_REL)
                begin
                    return REL_BITMAP_BYTES;
                end
                if (sub == SUB_EV_ABS)
                begin
                    return ABS_BITMAP_BYTES;
                end
                return 8'd0;
            end
            default:     return 8'd0;
        endcase
    endfunction

    // Bitmaps and axis info only answer at their exact word position.
    function automatic logic [31:0] payload_word(input logic [7:0] sel, input logic [7:0] sub,
                                                 input int pos);
        case (sel)
            SEL_NAME:   return text_word(MOUSE_NAME, pos);
            SEL_SERIAL: return text_word(MOUSE_SERIAL, pos);
            SEL_IDS:    return text_word(MOUSE_IDS, pos);
            SEL_EVBITS:
            begin
                if (sub == SUB_EV_ABS && pos == 0)
                begin
                    return ABS_AXES_BITS;
                end
                if (sub == SUB_EV_REL && pos == 0)
                begin
                    return WHEEL_BITS;
                end
                if (sub == SUB_EV_KEY && pos == BUTTON_WORD_POS)
                begin
                    return BUTTON_BITS;
                end
                return 32'd0;
            end
            SEL_ABSINFO:
            begin
                if (pos == AXIS_MAX_WORD_POS && sub == SUB_ABS_X)
                begin
                    return {16'd0, x_limit};
                end
                if (pos == AXIS_MAX_WORD_POS && sub == SUB_ABS_Y)
                begin
                    return {16'd0, y_limit};
                end
                return 32'd0;
            end
            default:    return 32'd0;
        endcase
    endfunction

    // Result of one access; a write at offset zero also updates the select word.
    function automatic logic [31:0] access_result(input logic op, input logic [7:0] off,
                                                  input logic [31:0] wdata);
        logic [31:0] r;
        r = 32'd0;
        if (op == OP_WRITE)
        begin
            if (off == 8'd0)
            begin
                select_word = wdata;
            end
        end
        else if (off == 8'd0)
        begin
            r = {select_word[31:24], payload_size(select_word[7:0], select_word[15:8]),
                 select_word[15:0]};
        end
        else if (off >= PAYLOAD_LO && off < PAYLOAD_HI)
        begin
            r = payload_word(select_word[7:0], select_word[15:8], int'(off - PAYLOAD_LO));
        end
        return r;
    endfunction

    // One process watches both channels. Results are checked before the item
    // accepted at the same edge is predicted, so the queue order matches the
    // order in which the block sees the accesses.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_word = 32'd0;
            x_limit = AXIS_MAX_RESET;
            y_limit = AXIS_MAX_RESET;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reads.size() == 0)
                begin
                    $display("%0t: read_data %08h arrived with nothing expected",
                             $time, read_data);
                    mismatch_count++;
                end
                else
                begin
                    want_read = expected_reads.pop_front();
                    if (read_data !== want_read)
                    begin
                        $display("%0t: read_data mismatch, expected %08h, got %08h",
                                 $time, want_read, read_data);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_reads.push_back(access_result(opcode, offset, write_data));
            end
        end
    end

    // Receiver side. A pulse on hold_start holds the result channel off for a
    // long stretch; otherwise the receiver stalls at random at the current rate.
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offers one access and returns at the edge where the block takes it.
    // Called at a rising-edge time step; the payload holds while stalled.
    task automatic send_access(input logic op, input logic [7:0] off, input logic [31:0] wdata);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        offset <= off;
        write_data <= wdata;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Stops offering items and waits until every expected result has come,
    // then waits out SETTLE_CYCLES so that the block is idle.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_reads.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both axis maxima; only called while the block is idle.
    task automatic set_axis_limits(input logic [15:0] x, input logic [15:0] y);
        cfg_we <= 1'b1;
        cfg_index <= CFG_X_MAX;
        cfg_data <= x;
        @(posedge clk);
        x_limit = x;
        cfg_index <= CFG_Y_MAX;
        cfg_data <= y;
        @(posedge clk);
        y_limit = y;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] random_select_word();
        logic [31:0] w;
        logic [7:0] sel;
        logic [7:0] sub;
        w = $urandom;
        case ($urandom_range(5))
            0:       sel = SEL_NAME;
            1:       sel = SEL_SERIAL;
            2:       sel = SEL_IDS;
            3:       sel = SEL_EVBITS;
            4:       sel = SEL_ABSINFO;
            default: sel = 8'($urandom_range(255));
        endcase
        sub = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
        w[15:0] = {sub, sel};
        return w;
    endfunction

    // Mostly word-aligned payload offsets, some offset-zero reads and some
    // unaligned or out-of-window offsets.
    function automatic logic [7:0] random_read_offset();
        case ($urandom_range(9))
            0, 1:    return 8'd0;
            2:       return 8'($urandom_range(255));
            3, 4:    return 8'($urandom_range(PAYLOAD_HI - 1, PAYLOAD_LO));
            default: return PAYLOAD_LO + 8'(4 * $urandom_range(8));
        endcase
    endfunction

    // Axis info for both axes, with a read of the select word.
    task automatic test_axis_info();
        send_access(OP_WRITE, 8'd0, {16'd0, SUB_ABS_X, SEL_ABSINFO});
        send_access(OP_READ, 8'd0, 32'd0);
        send_access(OP_READ, PAYLOAD_LO + 8'(AXIS_MAX_WORD_POS), 32'd0);
        send_access(OP_WRITE, 8'd0, {16'd0, SUB_ABS_Y, SEL_ABSINFO});
        send_access(OP_READ, PAYLOAD_LO + 8'(AXIS_MAX_WORD_POS), 32'd0);
    endtask

    // Name, serial and id strings, including unaligned reads across the end.
    task automatic test_strings();
        send_access(OP_WRITE, 8'd0, {24'hFFFFFF, SEL_NAME});
        send_access(OP_READ, 8'd0, 32'd0);
        send_access(OP_READ, PAYLOAD_LO, 32'd0);
        send_access(OP_READ, PAYLOAD_LO + 8'd9, 32'hFFFF_FFFF);
        send_access(OP_READ, PAYLOAD_LO + 8'd11, 32'd0);
        send_access(OP_WRITE, 8'd0, {24'd0, SEL_SERIAL});
        send_access(OP_READ, PAYLOAD_LO + 8'd8, 32'd0);
        send_access(OP_WRITE, 8'd0, {24'd0, SEL_IDS});
        send_access(OP_READ, PAYLOAD_LO, 32'd0);
    endtask

    // Key, relative and absolute bitmaps, plus an unknown subselect.
    task automatic test_event_bits();
        send_access(OP_WRITE, 8'd0, {16'd0, SUB_EV_KEY, SEL_EVBITS});
        send_access(OP_READ, 8'd0, 32'd0);
        send_access(OP_READ, PAYLOAD_LO + 8'(BUTTON_WORD_POS), 32'd0);
        send_access(OP_WRITE, 8'd0, {16'd0, SUB_EV_REL, SEL_EVBITS});
        send_access(OP_READ, PAYLOAD_LO, 32'd0);
        send_access(OP_WRITE, 8'd0, {16'd0, SUB_EV_ABS, SEL_EVBITS});
        send_access(OP_READ, PAYLOAD_LO, 32'd0);
        send_access(OP_WRITE, 8'd0, {16'd0, 8'd4, SEL_EVBITS});
        send_access(OP_READ, 8'd0, 32'd0);
    endtask

    // A write away from offset zero is dropped, reads outside the window give
    // zero, and an unknown select has no size and no payload.
    task automatic test_offsets_and_ignores();
        send_access(OP_WRITE, 8'd255, 32'hFFFF_FFFF);
        send_access(OP_READ, 8'd0, 32'd0);
        send_access(OP_READ, 8'd255, 32'd0);
        send_access(OP_READ, PAYLOAD_LO - 8'd1, 32'd0);
        send_access(OP_READ, PAYLOAD_HI, 32'd0);
        send_access(OP_WRITE, 8'd0, 32'hFFFF_FFFF);
        send_access(OP_READ, 8'd0, 32'd0);
        send_access(OP_READ, PAYLOAD_LO, 32'd0);
    endtask

    // The receiver holds off long enough that the block fills up and stalls
    // its input while the sender keeps offering items back to back.
    task automatic test_backpressure();
        int saved_idle;
        settle();
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        send_access(OP_WRITE, 8'd0, {16'd0, SUB_ABS_X, SEL_ABSINFO});
        repeat (8)
        begin
            send_access(OP_READ, 8'd0, $urandom);
            send_access(OP_READ, PAYLOAD_LO + 8'(AXIS_MAX_WORD_POS), $urandom);
        end
        send_idle_pct = saved_idle;
    endtask

    // Random traffic at one idle and stall setting and one axis setting. Most of it is
    // a select write followed by a burst of reads; the rest is random noise.
    // Halfway through the sender pauses until every result is back.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [15:0] x, input logic [15:0] y,
                                       input int count);
        int sent;
        int burst;
        bit paused;
        logic [7:0] noise_off;
        settle();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        set_axis_limits(x, y);
        sent = 0;
        paused = 1'b0;
        while (sent < count)
        begin
            if (!paused && sent >= count / 2)
            begin
                settle();
                paused = 1'b1;
            end
            if ($urandom_range(4) != 0)
            begin
                send_access(OP_WRITE, 8'd0, random_select_word());
                sent++;
                burst = $urandom_range(10, 3);
                repeat (burst)
                begin
                    if ($urandom_range(15) == 0)
                    begin
                        // Dropped write; it does not count as traffic.
                        send_access(OP_WRITE, 8'($urandom_range(255, 1)), $urandom);
                    end
                    else
                    begin
                        send_access(OP_READ, random_read_offset(), $urandom);
                        sent++;
                    end
                end
            end
            else
            begin
                noise_off = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
                send_access(1'($urandom_range(1)), noise_off, $urandom);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs with the first idle setting and reset axis maxima.
        test_axis_info();
        test_strings();
        test_event_bits();
        test_offsets_and_ignores();

        // Axis maxima at their extremes.
        settle();
        set_axis_limits(16'd0, 16'hFFFF);
        test_axis_info();
        settle();
        set_axis_limits(16'hFFFF, 16'd0);
        test_axis_info();

        test_backpressure();

        test_random_traffic(28, 69, 16'd1, 16'h8000, 620);
        test_random_traffic(69, 28, 16'($urandom), 16'($urandom), 620);
        test_random_traffic(0, 0, 16'hFFFF, 16'hFFFF, 620);

        settle();
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* input_device_config_space.f */
rtl/idcs_pkg.sv
rtl/idcs_decode.sv
rtl/input_device_config_space.sv
bench/testbench.sv
